@@ hdl/assert_macros.svh @@
// Assertion macros used by the key table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lpkt_pkg.sv @@
// Package: command codes, result codes, controller states and control structs.
`timescale 1ns / 1ps

package lpkt_pkg;

  localparam int KEY_W = 32;

  // Command codes on in_cmd (code 3 is a no-op)
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Result codes on out_status
  localparam logic [1:0] RES_FOUND    = 2'd0;
  localparam logic [1:0] RES_INSERTED = 2'd1;
  localparam logic [1:0] RES_FULL     = 2'd2;
  localparam logic [1:0] RES_DONE     = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RM_READ,
    S_RM_CHECK,
    S_CLEAR,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;
    logic       hash_start;
    logic       load_home;
    logic       load_rm;
    logic       advance;
    logic       ins_write;
    logic       rm_write;
    logic       sweep_start;
    logic       sweep_write;
    logic       set_res;
    logic [1:0] res_status;
    logic       load_out;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hash_done;
    logic rd_valid;
    logic key_match;
    logic next_is_home;
    logic sweep_last;
    logic rm_in_range;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hdl/linear_probe_key_table.sv @@
// Top level of the linear probing key table.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Open-addressed table of SLOTS 32-bit keys. An insert hashes the key to
// key mod SLOTS and probes forward one slot per cycle through the slot RAM's
// read port, reporting found, inserted or full, with the slot index on found
// or inserted; remove frees one slot by index (no tombstone) and clear empties
// the table. One transaction is in work at a time. When SLOTS is not a power
// of two, the home slot comes from a reciprocal-multiply remainder unit. Clear
// rewrites every RAM entry, one per cycle. After reset the same clearing pass
// runs before in_ready rises. A finished result waits in the output register
// until out_ready.
module linear_probe_key_table #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [7:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot,
  output logic [8:0]  out_occupied
);
  import lpkt_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  lpkt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  lpkt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (ctl_cmd),
    .sts           (dp_sts),
    .in_key        (in_key),
    .in_slot_index (in_slot_index),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_occupied  (out_occupied)
  );

  // One transaction in work at a time
  `ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second transaction accepted while busy")
  // No input is taken while the RAM is being swept
  `ASSERT_IMP(a_sweep_blocks_input, clk, rst_n, ctl_cmd.sweep_write, !in_ready, "input ready during clearing sweep")
  // Every insert write reports an inserted result
  `ASSERT_IMP(a_insert_reports, clk, rst_n, ctl_cmd.ins_write, ctl_cmd.set_res && ctl_cmd.res_status == RES_INSERTED, "slot written without inserted result")
  // Full, remove, clear and no-op results carry slot zero
  `ASSERT_IMP(a_slot_zero, clk, rst_n, out_valid && (out_status == RES_FULL || out_status == RES_DONE), out_slot == 8'd0, "nonzero slot on full or done result")

endmodule

@@ hdl/lpkt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lpkt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/lpkt_datapath.sv @@
// Datapath: hash unit, probe pointer, slot RAM, occupancy count and output register.
`timescale 1ns / 1ps

module lpkt_datapath #(
  parameter int SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lpkt_pkg::ctl_cmd_t cmd,
  output lpkt_pkg::dp_sts_t  sts,
  input  logic [31:0]        in_key,
  input  logic [7:0]         in_slot_index,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [7:0]         out_slot,
  output logic [8:0]         out_occupied
);
  import lpkt_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MEM_W = KEY_W + 1;

  logic [KEY_W-1:0] key_r;
  logic [7:0]       rm_idx_r;
  logic [IDX_W-1:0] probe_idx_r, probe_idx_nxt;
  logic [IDX_W-1:0] next_idx, home, rm_addr, rd_addr;
  logic [IDX_W+7:0] rm_wide, slot_wide;
  logic [16:0]      rm_ext;
  logic             hash_done;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W+8:0] occ_wide;
  logic             wr_en;
  logic [MEM_W-1:0] wr_data, rd_data;
  logic [1:0]       res_status_r;
  logic [7:0]       res_slot_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [7:0]       out_slot_r;
  logic [8:0]       out_occupied_r;

  // Capture the transaction payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_r    <= in_key;
      rm_idx_r <= in_slot_index;
    end
  end

  // Home slot: key modulo SLOTS
  if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
    assign home      = key_r[IDX_W-1:0];
    assign hash_done = 1'b1;
  end else begin : g_div
    // Reciprocal multiplication: the quotient is registered first, then the remainder
    localparam int             SHIFT     = KEY_W + IDX_W;
    localparam logic [KEY_W:0] MAGIC     = (KEY_W + 1)'(((64'd1 << SHIFT) / 64'(SLOTS)) + 64'd1);
    localparam logic [1:0]     STEP_QUOT = 2'd0;
    localparam logic [1:0]     STEP_REM  = 2'd1;
    localparam logic [1:0]     STEP_DONE = 2'd2;

    logic [1:0]       hash_step_r;
    logic [2*KEY_W:0] prod;
    logic [KEY_W-1:0] quot_r;
    logic [KEY_W-1:0] back, rem_full;
    logic [IDX_W-1:0] rem_r;

    assign prod     = {{KEY_W{1'b0}}, 1'b0, key_r} * {{KEY_W{1'b0}}, MAGIC};
    assign back     = quot_r * KEY_W'(SLOTS);
    assign rem_full = key_r - back;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hash_step_r <= STEP_DONE;
      end else if (cmd.hash_start) begin
        hash_step_r <= STEP_QUOT;
      end else if (hash_step_r != STEP_DONE) begin
        hash_step_r <= hash_step_r + 2'd1;
      end
    end

    always_ff @(posedge clk) begin
      if (hash_step_r == STEP_QUOT) begin
        quot_r <= KEY_W'(prod >> SHIFT);
      end
      if (hash_step_r == STEP_REM) begin
        rem_r <= rem_full[IDX_W-1:0];
      end
    end

    assign home      = rem_r;
    assign hash_done = (hash_step_r == STEP_DONE);
  end

  // Probe pointer with wrap-around; also walks the clearing sweep
  assign next_idx = (probe_idx_r == IDX_W'(SLOTS - 1)) ? '0 : probe_idx_r + 1'b1;
  assign rm_wide  = {{IDX_W{1'b0}}, rm_idx_r};
  assign rm_addr  = rm_wide[IDX_W-1:0];
  assign rm_ext   = {9'd0, rm_idx_r};

  always_comb begin
    probe_idx_nxt = probe_idx_r;
    if (cmd.sweep_start) begin
      probe_idx_nxt = '0;
    end else if (cmd.load_home) begin
      probe_idx_nxt = home;
    end else if (cmd.load_rm) begin
      probe_idx_nxt = rm_addr;
    end else if (cmd.advance || cmd.sweep_write) begin
      probe_idx_nxt = next_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_idx_r <= '0;
    end else begin
      probe_idx_r <= probe_idx_nxt;
    end
  end

  // Slot RAM: {valid, key}
  assign rd_addr = cmd.load_home ? home : (cmd.load_rm ? rm_addr : next_idx);
  assign wr_en   = cmd.ins_write | cmd.rm_write | cmd.sweep_write;
  assign wr_data = cmd.ins_write ? {1'b1, key_r} : '0;

  lpkt_ram #(
    .WIDTH (MEM_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (probe_idx_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Occupied slot count
  always_comb begin
    count_nxt = count_r;
    if (cmd.sweep_write) begin
      count_nxt = '0;
    end else if (cmd.ins_write) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.rm_write) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result of the current transaction
  assign slot_wide = {8'd0, probe_idx_r};

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      if (cmd.res_status == RES_FOUND || cmd.res_status == RES_INSERTED) begin
        res_slot_r <= slot_wide[7:0];
      end else begin
        res_slot_r <= 8'd0;
      end
    end
  end

  // Output register
  assign occ_wide = {9'd0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r   <= res_status_r;
      out_slot_r     <= res_slot_r;
      out_occupied_r <= occ_wide[8:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot     = out_slot_r;
  assign out_occupied = out_occupied_r;

  // Status back to the controller
  always_comb begin
    sts.hash_done    = hash_done;
    sts.rd_valid     = rd_data[MEM_W-1];
    sts.key_match    = (rd_data[KEY_W-1:0] == key_r);
    sts.next_is_home = (next_idx == home);
    sts.sweep_last   = (probe_idx_r == IDX_W'(SLOTS - 1));
    sts.rm_in_range  = (rm_ext < 17'(SLOTS));
    sts.out_free     = !out_valid_r || out_ready;
  end

endmodule

@@ hdl/lpkt_ctrl.sv @@
// Controller: sequences hashing, probing, removal, clearing and result handoff.
`timescale 1ns / 1ps

module lpkt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  lpkt_pkg::dp_sts_t  sts,
  output lpkt_pkg::ctl_cmd_t cmd
);
  import lpkt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_INSERT: state_nxt = S_HASH;
            CMD_REMOVE: state_nxt = S_RM_READ;
            CMD_CLEAR:  state_nxt = S_CLEAR;
            default:    state_nxt = S_FINISH;
          endcase
        end
      end
      S_HASH: begin
        if (sts.hash_done) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (!sts.rd_valid || sts.key_match || sts.next_is_home) state_nxt = S_FINISH;
      end
      S_RM_READ:  state_nxt = S_RM_CHECK;
      S_RM_CHECK: state_nxt = S_FINISH;
      S_CLEAR: begin
        if (sts.sweep_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.sweep_write = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_cmd)
            CMD_INSERT: cmd.hash_start = 1'b1;
            CMD_REMOVE: ;
            CMD_CLEAR:  cmd.sweep_start = 1'b1;
            default: begin
              cmd.set_res    = 1'b1;
              cmd.res_status = RES_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        cmd.load_home = sts.hash_done;
      end
      S_PROBE: begin
        if (!sts.rd_valid) begin
          cmd.ins_write  = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = RES_INSERTED;
        end else if (sts.key_match) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = RES_FOUND;
        end else if (sts.next_is_home) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = RES_FULL;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_RM_READ: begin
        cmd.load_rm = 1'b1;
      end
      S_RM_CHECK: begin
        cmd.rm_write   = sts.rd_valid && sts.rm_in_range;
        cmd.set_res    = 1'b1;
        cmd.res_status = RES_DONE;
      end
      S_CLEAR: begin
        cmd.sweep_write = 1'b1;
        if (sts.sweep_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = RES_DONE;
        end
      end
      S_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ verif/linear_probe_key_table_tb.sv @@
// Self-checking testbench for the linear probing key table.
`timescale 1ns / 1ps

module linear_probe_key_table_tb;
  import lpkt_pkg::*;

  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned IDLE_PCT = 28;
  localparam logic [1:0] CMD_NOOP = 2'd3;

  // One expected result transaction
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
    logic [8:0] occupied;
  } outcome_t;

  // Shadow copy of the slot table plus the queue of outcomes still owed by the block
  class probe_table_tracker;
    logic [31:0] slot_key [SLOT_COUNT];
    bit slot_used [SLOT_COUNT];
    int unsigned occupied;
    outcome_t pending[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned status_tally [4];

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      occupied = 0;
      failures = 0;
      checked = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // Apply one accepted command to the shadow table and queue its outcome
    function void note_request(logic [1:0] cmd, logic [31:0] key, logic [7:0] idx);
      outcome_t res;
      int unsigned home;
      int unsigned pos;
      bit done;
      res.status = RES_DONE;
      res.slot = '0;
      case (cmd)
        CMD_INSERT: begin
          home = key % SLOT_COUNT;
          pos = home;
          done = 1'b0;
          while (!done) begin
            if (!slot_used[pos]) begin
              slot_key[pos] = key;
              slot_used[pos] = 1'b1;
              occupied++;
              res.status = RES_INSERTED;
              res.slot = pos[7:0];
              done = 1'b1;
            end else if (slot_key[pos] == key) begin
              res.status = RES_FOUND;
              res.slot = pos[7:0];
              done = 1'b1;
            end else begin
              pos = (pos + 1) % SLOT_COUNT;
              if (pos == home) begin
                res.status = RES_FULL;
                done = 1'b1;
              end
            end
          end
        end
        CMD_REMOVE: begin
          if (idx < SLOT_COUNT && slot_used[idx]) begin
            slot_used[idx] = 1'b0;
            if (occupied > 0) occupied--;
          end
        end
        CMD_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          occupied = 0;
        end
        default: ;
      endcase
      res.occupied = occupied[8:0];
      pending.push_back(res);
    endfunction

    // Compare one result transaction against the oldest outcome owed
    function void check_result(logic [1:0] st, logic [7:0] sl, logic [8:0] occ);
      outcome_t exp;
      checked++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected result status %0d slot %0d occupied %0d", st, sl, occ);
        return;
      end
      exp = pending.pop_front();
      status_tally[exp.status]++;
      if (st !== exp.status || sl !== exp.slot || occ !== exp.occupied) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: result %0d expected status %0d slot %0d occupied %0d, got %0d %0d %0d",
                   checked, exp.status, exp.slot, exp.occupied, st, sl, occ);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_NOOP;
  logic [31:0] in_key = '0;
  logic [7:0]  in_slot_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_slot;
  logic [8:0]  out_occupied;

  probe_table_tracker tracker = new();
  bit steady = 1'b0;
  int unsigned cycles = 0;
  logic [31:0] recent_keys[$];

  linear_probe_key_table #(.SLOTS(SLOT_COUNT)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_key(in_key),
    .in_slot_index(in_slot_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_slot(out_slot),
    .out_occupied(out_occupied)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results owed", cycles,
               tracker.pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random backpressure, check on each accepted transaction
  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_status, out_slot, out_occupied);
  end

  // Drive one command; called and returns at a falling edge
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] key,
                              input logic [7:0] idx);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_key = key;
    in_slot_index = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(cmd, key, idx);
    if (cmd == CMD_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  // Key with a home slot in a crowded region, an earlier key for a lookup hit, or a random key
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 70)
      return ($urandom() & 32'hFFFF_FF00) | ($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                                 : $urandom_range(250, 255));
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 99) < 60)
      return 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(248, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned r;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: no-op, removes on an empty table, wrap-around, broken chains, clear
    send_request(CMD_NOOP, 32'hFFFF_FFFF, 8'hFF);
    send_request(CMD_REMOVE, 32'h0, 8'h00);
    send_request(CMD_INSERT, 32'h0000_0000, 8'h00);
    send_request(CMD_INSERT, 32'h0000_0000, 8'hFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 8'h00);
    send_request(CMD_INSERT, 32'h0000_0100, 8'h00);
    send_request(CMD_INSERT, 32'h1234_56FF, 8'h00);
    send_request(CMD_INSERT, 32'h0000_0200, 8'h00);
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 8'h01);
    send_request(CMD_INSERT, 32'h0000_0200, 8'h00);
    send_request(CMD_INSERT, 32'h1234_56FF, 8'h00);
    send_request(CMD_REMOVE, 32'h0, 8'h01);
    send_request(CMD_REMOVE, 32'h0, 8'h01);
    send_request(CMD_REMOVE, 32'h0, 8'hFF);
    send_request(CMD_NOOP, 32'h0, 8'h00);
    send_request(CMD_CLEAR, 32'hA5A5_5A5A, 8'h5A);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 8'h00);
    send_request(CMD_INSERT, 32'h8000_0000, 8'h00);
    send_request(CMD_CLEAR, 32'h0, 8'h00);
    send_request(CMD_REMOVE, 32'h0, 8'hAA);
    drain_results();

    // Fill the table past capacity, then look up and punch holes while full
    send_request(CMD_CLEAR, $urandom(), 8'($urandom_range(0, 255)));
    repeat (262) send_request(CMD_INSERT, $urandom(), 8'($urandom_range(0, 255)));
    repeat (6)
      send_request(CMD_INSERT, recent_keys[$urandom_range(0, recent_keys.size() - 1)],
                   8'($urandom_range(0, 255)));
    repeat (10) send_request(CMD_REMOVE, $urandom(), 8'($urandom_range(0, 255)));
    repeat (10) send_request(CMD_INSERT, pick_key(), 8'($urandom_range(0, 255)));
    drain_results();

    // Random mix of all commands; one stretch runs with no idling on either side
    for (int i = 0; i < 320; i++) begin
      steady = (i >= 100 && i < 180);
      r = $urandom_range(0, 99);
      if (r < 60)
        send_request(CMD_INSERT, pick_key(), 8'($urandom_range(0, 255)));
      else if (r < 84)
        send_request(CMD_REMOVE, $urandom(), pick_index());
      else if (r < 92)
        send_request(CMD_NOOP, $urandom(), 8'($urandom_range(0, 255)));
      else if (r < 95)
        send_request(CMD_CLEAR, $urandom(), 8'($urandom_range(0, 255)));
      else
        send_request(CMD_INSERT, $urandom(), 8'($urandom_range(0, 255)));
    end
    steady = 1'b0;

    drain_results();
    repeat (SLOT_COUNT + 40) @(posedge clk);

    $display("Checked %0d results: %0d inserted, %0d found, %0d full, %0d remove/clear/no-op",
             tracker.checked, tracker.status_tally[RES_INSERTED],
             tracker.status_tally[RES_FOUND], tracker.status_tally[RES_FULL],
             tracker.status_tally[RES_DONE]);
    $display("Mismatches: %0d, results still owed: %0d", tracker.failures,
             tracker.pending.size());
    if (tracker.failures == 0 && tracker.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
